// File: rtl/fct_pkg.sv
// ----------------------------------------------------------------------------
// fct_pkg
// Shared types and constants of the frustum cull test: plane register layout,
// test codes and per-plane result flags.
// ----------------------------------------------------------------------------
package fct_pkg;

	localparam int NUM_PLANES    = 6;
	localparam int COEF_BITS     = 16;
	localparam int RADIUS_BITS   = 15;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 64;

	// test kinds
	typedef enum logic [1:0] {
		OP_POINT  = 2'd0,
		OP_BOX    = 2'd1,
		OP_SPHERE = 2'd2
	} fct_op_t;

	// plane register: d in the top 16 bits, a in the low 16
	typedef struct packed {
		logic signed [COEF_BITS-1:0] d;
		logic signed [COEF_BITS-1:0] c;
		logic signed [COEF_BITS-1:0] b;
		logic signed [COEF_BITS-1:0] a;
	} fct_plane_t;

	// per-plane outcome of one distance
	typedef struct packed {
		logic above;    // distance strictly positive
		logic near;     // distance at or above minus the scaled radius
	} fct_flags_t;

endpackage

// File: rtl/fct_plane_lane.sv
// ----------------------------------------------------------------------------
// fct_plane_lane
// One plane of the cull test: products, per-axis corner pick, distance sum
// and the two sign flags. Three pipeline registers, all held by en.
// ----------------------------------------------------------------------------
module fct_plane_lane
	import fct_pkg::*;
#(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS  = 14
) (
	input  logic                          clk,
	input  logic                          en,
	input  fct_plane_t                    plane,
	input  logic signed [COORD_BITS-1:0]  x1,
	input  logic signed [COORD_BITS-1:0]  y1,
	input  logic signed [COORD_BITS-1:0]  z1,
	input  logic signed [COORD_BITS-1:0]  x2,
	input  logic signed [COORD_BITS-1:0]  y2,
	input  logic signed [COORD_BITS-1:0]  z2,
	input  logic                          is_box_s1,
	input  logic        [RADIUS_BITS-1:0] radius_s3,
	output fct_flags_t                    flags_s3
);

	localparam int PW = COEF_BITS + COORD_BITS;
	localparam int MW = (COORD_BITS > FRAC_BITS) ? COORD_BITS : FRAC_BITS;
	localparam int DW = MW + COEF_BITS + 2;
	localparam int RW = RADIUS_BITS + FRAC_BITS;

	logic signed [PW-1:0] px1_s1, py1_s1, pz1_s1;
	logic signed [PW-1:0] px2_s1, py2_s1, pz2_s1;
	logic signed [PW-1:0] tx_s2, ty_s2, tz_s2;
	logic signed [DW-1:0] dist_s3;
	logic signed [DW-1:0] d_ext;
	logic        [RW-1:0] rad_scaled;
	logic signed [DW:0]   near_sum;

	// stage 1: six products
	always_ff @(posedge clk) begin
		if (en) begin
			px1_s1 <= PW'(plane.a) * PW'(x1);
			py1_s1 <= PW'(plane.b) * PW'(y1);
			pz1_s1 <= PW'(plane.c) * PW'(z1);
			px2_s1 <= PW'(plane.a) * PW'(x2);
			py2_s1 <= PW'(plane.b) * PW'(y2);
			pz2_s1 <= PW'(plane.c) * PW'(z2);
		end
	end

	// stage 2: the farthest corner in front is the per-axis maximum
	always_ff @(posedge clk) begin
		if (en) begin
			tx_s2 <= (is_box_s1 && (px2_s1 > px1_s1)) ? px2_s1 : px1_s1;
			ty_s2 <= (is_box_s1 && (py2_s1 > py1_s1)) ? py2_s1 : py1_s1;
			tz_s2 <= (is_box_s1 && (pz2_s1 > pz1_s1)) ? pz2_s1 : pz1_s1;
		end
	end

	// stage 3: distance scaled by 2^FRAC_BITS
	assign d_ext = DW'(plane.d) <<< FRAC_BITS;

	always_ff @(posedge clk) begin
		if (en) begin
			dist_s3 <= DW'(tx_s2) + DW'(ty_s2) + DW'(tz_s2) + d_ext;
		end
	end

	assign rad_scaled = RW'(radius_s3) << FRAC_BITS;
	assign near_sum   = (DW+1)'(dist_s3) + $signed((DW+1)'(rad_scaled));

	assign flags_s3.above = !dist_s3[DW-1] && (|dist_s3);
	assign flags_s3.near  = !near_sum[DW];

endmodule

// File: rtl/frustum_cull_test.sv
// ----------------------------------------------------------------------------
// frustum_cull_test
// Tests points, boxes and spheres against six view-frustum planes and
// returns one visibility bit per item.
// ----------------------------------------------------------------------------
// usage
//   planes are written through wr_en / wr_index / wr_data while the block is
//   idle; index 0..5 is right, left, bottom, top, far, near; other indexes
//   are ignored. each plane packs a, b, c (Q1.FRAC_BITS) and d (world units)
//   input items (op, x1..z2, radius) are taken on in_valid with in_stall low
//   op point: visible when every plane distance is above zero
//   op box: culled when all eight corners sit at or behind one plane; the
//   test uses the per-axis maximum of a*x, so no corner loop is needed
//   op sphere: culled when a distance is below minus the radius
//   the unused op code gives visible low
//   pipeline: four register stages (products, corner pick, distance sum,
//   compare and and-reduce); the result stands on out_valid once the item
//   has passed all four; one item is taken every cycle while in_stall is low
//   the six lanes of 16 x COORD_BITS multipliers set the depth of stage one
//   out_stall with out_valid high freezes the whole pipeline and raises
//   in_stall in the same cycle; nothing is lost or repeated
//   reset clears the planes to zero and empties the pipeline; with zero
//   planes points and boxes are culled and spheres are visible
// ----------------------------------------------------------------------------
module frustum_cull_test
	import fct_pkg::*;
#(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS  = 14
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          wr_en,
	input  logic [CFG_IDX_BITS-1:0]       wr_index,
	input  logic [CFG_DATA_BITS-1:0]      wr_data,
	// input items
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    op,
	input  logic signed [COORD_BITS-1:0]  x1,
	input  logic signed [COORD_BITS-1:0]  y1,
	input  logic signed [COORD_BITS-1:0]  z1,
	input  logic signed [COORD_BITS-1:0]  x2,
	input  logic signed [COORD_BITS-1:0]  y2,
	input  logic signed [COORD_BITS-1:0]  z2,
	input  logic [RADIUS_BITS-1:0]        radius,
	// results
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          visible
);

	fct_plane_t plane_q [NUM_PLANES];

	logic                   en;
	logic                   vld_s1, vld_s2, vld_s3, vld_s4;
	logic [1:0]             op_s1, op_s2, op_s3;
	logic [RADIUS_BITS-1:0] rad_s1, rad_s2, rad_s3;
	logic                   vis_s4;
	logic                   is_box_s1;
	logic                   vis_next;
	logic                   all_above, all_near;
	fct_flags_t             flags_s3 [NUM_PLANES];

	// plane registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PLANES; i++) begin
				plane_q[i] <= '0;
			end
		end else if (wr_en) begin
			for (int i = 0; i < NUM_PLANES; i++) begin
				if (wr_index == CFG_IDX_BITS'(i)) begin
					plane_q[i] <= wr_data;
				end
			end
		end
	end

	// whole pipeline moves unless a finished item is held at the output
	assign en       = !(vld_s4 && out_stall);
	assign in_stall = !en;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// op and radius travel alongside the lanes
	always_ff @(posedge clk) begin
		if (en) begin
			op_s1  <= op;
			op_s2  <= op_s1;
			op_s3  <= op_s2;
			rad_s1 <= radius;
			rad_s2 <= rad_s1;
			rad_s3 <= rad_s2;
			vis_s4 <= vis_next;
		end
	end

	assign is_box_s1 = (op_s1 == OP_BOX);

	for (genvar p = 0; p < NUM_PLANES; p++) begin : g_lane
		fct_plane_lane #(
			.COORD_BITS(COORD_BITS),
			.FRAC_BITS (FRAC_BITS)
		) u_lane (
			.clk      (clk),
			.en       (en),
			.plane    (plane_q[p]),
			.x1       (x1),
			.y1       (y1),
			.z1       (z1),
			.x2       (x2),
			.y2       (y2),
			.z2       (z2),
			.is_box_s1(is_box_s1),
			.radius_s3(rad_s3),
			.flags_s3 (flags_s3[p])
		);
	end

	// and-reduce over the six planes
	always_comb begin
		all_above = 1'b1;
		all_near  = 1'b1;
		for (int i = 0; i < NUM_PLANES; i++) begin
			all_above = all_above & flags_s3[i].above;
			all_near  = all_near & flags_s3[i].near;
		end
	end

	always_comb begin
		case (op_s3)
			OP_POINT:  vis_next = all_above;
			OP_BOX:    vis_next = all_above;
			OP_SPHERE: vis_next = all_near;
			default:   vis_next = 1'b0;
		endcase
	end

	assign out_valid = vld_s4;
	assign visible   = vis_s4;

endmodule

// File: rtl/fct_checker.sv
// ----------------------------------------------------------------------------
// fct_checker
// Port-level checks of the frustum cull test: hold under stall, stall
// coupling, fixed latency and no result without an item.
// ----------------------------------------------------------------------------
module fct_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic visible
);

	// a held result keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(visible)))
		else $error("result changed while stalled");

	// input side only stalls behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a held result");

	// an accepted item reaches the output when nothing stalls it on the way
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		((in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall)
		|=> out_valid)
		else $error("item lost in pipeline");

	// once every stage has moved on with no accepted item, the output is empty
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		(!(in_valid && !in_stall) && !out_stall) [*4] |=> !out_valid)
		else $error("result without item");

endmodule

bind frustum_cull_test fct_checker u_fct_checker (.*);

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// frustum cull test bench
// Streams point, box and sphere tests through frustum_cull_test under several
// plane sets and random flow control, predicts every visibility bit and
// compares each result with the prediction in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench
	import fct_pkg::*;
();

	localparam int COORD_BITS       = 16;
	localparam int FRAC_BITS        = 14;
	localparam int NUM_CORNERS      = 8;
	localparam int DRAIN_CYCLES     = 8;   // pipeline depth plus some margin
	localparam int RANDOM_PER_PHASE = 175;
	localparam int NUM_PHASES       = 6;

	// op code that asks for no test
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// register indexes of the config port, spares must be ignored
	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_RIGHT    = 3'd0,
		REG_LEFT     = 3'd1,
		REG_BOTTOM   = 3'd2,
		REG_TOP      = 3'd3,
		REG_BACK     = 3'd4,
		REG_FRONT    = 3'd5,
		REG_SPARE_LO = 3'd6,
		REG_SPARE_HI = 3'd7
	} plane_reg_t;

	// plane sets, one per random phase in this order
	typedef enum int {
		SET_AXIS,       // box frustum around the z axis
		SET_OBLIQUE,    // random normals, origin inside every plane
		SET_MAX,        // every coefficient at its positive extreme
		SET_MIN,        // every coefficient at its negative extreme
		SET_RANDOM,     // any 64-bit pattern
		SET_MIXED       // each plane drawn from axis, oblique, zero and all ones
	} plane_set_t;

	typedef struct packed {
		logic [1:0]                   op;
		logic signed [COORD_BITS-1:0] x1;
		logic signed [COORD_BITS-1:0] y1;
		logic signed [COORD_BITS-1:0] z1;
		logic signed [COORD_BITS-1:0] x2;
		logic signed [COORD_BITS-1:0] y2;
		logic signed [COORD_BITS-1:0] z2;
		logic [RADIUS_BITS-1:0]       radius;
	} cull_item_t;

	// predicted visibility bits in item order, plus a copy of the planes
	class visibility_board;
		fct_plane_t planes [NUM_PLANES];
		bit         expected_visible [$];
		int         errors;

		function new();
			for (int i = 0; i < NUM_PLANES; i++)
				planes[i] = '0;
			errors = 0;
		endfunction

		function void set_plane(int idx, fct_plane_t value);
			if (idx < NUM_PLANES)
				planes[idx] = value;
		endfunction

		// exact distance scaled by 2^FRAC_BITS
		function longint plane_distance(fct_plane_t pl, longint x, longint y, longint z);
			return longint'($signed(pl.a)) * x + longint'($signed(pl.b)) * y
				+ longint'($signed(pl.c)) * z
				+ longint'($signed(pl.d)) * (longint'(1) <<< FRAC_BITS);
		endfunction

		function bit predict_visible(cull_item_t it);
			bit     vis;
			bit     any_above;
			longint reach;
			logic signed [COORD_BITS-1:0] cx, cy, cz;
			vis = (it.op != OP_UNUSED);
			reach = -(longint'(it.radius) <<< FRAC_BITS);
			for (int p = 0; p < NUM_PLANES; p++) begin
				case (it.op)
					OP_POINT: begin
						if (plane_distance(planes[p], it.x1, it.y1, it.z1) <= 0)
							vis = 1'b0;
					end
					OP_BOX: begin
						any_above = 1'b0;
						for (int k = 0; k < NUM_CORNERS; k++) begin
							cx = ((k & 4) != 0) ? it.x2 : it.x1;
							cy = ((k & 2) != 0) ? it.y2 : it.y1;
							cz = ((k & 1) != 0) ? it.z2 : it.z1;
							if (plane_distance(planes[p], cx, cy, cz) > 0)
								any_above = 1'b1;
						end
						if (!any_above)
							vis = 1'b0;
					end
					OP_SPHERE: begin
						// every plane is checked, a straddled plane culls nothing
						if (plane_distance(planes[p], it.x1, it.y1, it.z1) < reach)
							vis = 1'b0;
					end
					default: ;
				endcase
			end
			return vis;
		endfunction

		function void note_item(cull_item_t it);
			expected_visible.push_back(predict_visible(it));
		endfunction

		function void check_result(logic got);
			bit want;
			if (expected_visible.size() == 0) begin
				$display("%0t: result with no item pending, expected none, actual %b",
					$time, got);
				errors++;
			end else begin
				want = expected_visible.pop_front();
				if (got !== want) begin
					$display("%0t: visible mismatch, expected %b, actual %b",
						$time, want, got);
					errors++;
				end
			end
		endfunction

		function int pending();
			return expected_visible.size();
		endfunction
	endclass

	// every input known from time zero
	logic                         clk       = 1'b0;
	logic                         arst_n    = 1'b0;
	logic                         wr_en     = 1'b0;
	logic [CFG_IDX_BITS-1:0]      wr_index  = '0;
	logic [CFG_DATA_BITS-1:0]     wr_data   = '0;
	logic                         in_valid  = 1'b0;
	logic                         in_stall;
	logic [1:0]                   op        = '0;
	logic signed [COORD_BITS-1:0] x1        = '0;
	logic signed [COORD_BITS-1:0] y1        = '0;
	logic signed [COORD_BITS-1:0] z1        = '0;
	logic signed [COORD_BITS-1:0] x2        = '0;
	logic signed [COORD_BITS-1:0] y2        = '0;
	logic signed [COORD_BITS-1:0] z2        = '0;
	logic [RADIUS_BITS-1:0]       radius    = '0;
	logic                         out_valid;
	logic                         out_stall = 1'b0;
	logic                         visible;

	visibility_board board;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;

	frustum_cull_test #(
		.COORD_BITS (COORD_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.x1        (x1),
		.y1        (y1),
		.z1        (z1),
		.x2        (x2),
		.y2        (y2),
		.z2        (z2),
		.radius    (radius),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.visible   (visible)
	);

	always #1 clk = ~clk;

	// result side: check what is taken at this edge, then pick the next stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall)
				board.check_result(visible);
			out_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	// hard stop in case results never drain
	initial begin
		#2_000_000;
		$display("TEST FAILED");
		$finish;
	end

	function automatic fct_plane_t make_plane(int a, int b, int c, int d);
		fct_plane_t pl;
		pl.a = COEF_BITS'(a);
		pl.b = COEF_BITS'(b);
		pl.c = COEF_BITS'(c);
		pl.d = COEF_BITS'(d);
		return pl;
	endfunction

	// unit normals point inward, one Q1.14 unit is 16384
	function automatic fct_plane_t axis_plane(int idx);
		case (idx)
			REG_RIGHT:  return make_plane(-16384, 0, 0, 1000);
			REG_LEFT:   return make_plane(16384, 0, 0, 1000);
			REG_BOTTOM: return make_plane(0, 16384, 0, 1000);
			REG_TOP:    return make_plane(0, -16384, 0, 1000);
			REG_BACK:   return make_plane(0, 0, -16384, 2000);
			default:    return make_plane(0, 0, 16384, -16);
		endcase
	endfunction

	function automatic fct_plane_t oblique_plane();
		return make_plane(int'($urandom_range(32768)) - 16384,
			int'($urandom_range(32768)) - 16384,
			int'($urandom_range(32768)) - 16384,
			int'($urandom_range(100, 2500)));
	endfunction

	function automatic fct_plane_t build_plane(plane_set_t kind, int idx);
		case (kind)
			SET_AXIS:    return axis_plane(idx);
			SET_OBLIQUE: return oblique_plane();
			SET_MAX:     return make_plane(32767, 32767, 32767, 32767);
			SET_MIN:     return make_plane(-32768, -32768, -32768, -32768);
			SET_RANDOM:  return {$urandom, $urandom};
			default: begin
				case ($urandom_range(3))
					0:       return axis_plane(idx);
					1:       return oblique_plane();
					2:       return '0;
					default: return '1;
				endcase
			end
		endcase
	endfunction

	function automatic cull_item_t make_item(logic [1:0] kind, int ax, int ay, int az,
			int bx, int by, int bz, int r);
		cull_item_t it;
		it.op     = kind;
		it.x1     = COORD_BITS'(ax);
		it.y1     = COORD_BITS'(ay);
		it.z1     = COORD_BITS'(az);
		it.x2     = COORD_BITS'(bx);
		it.y2     = COORD_BITS'(by);
		it.z2     = COORD_BITS'(bz);
		it.radius = RADIUS_BITS'(r);
		return it;
	endfunction

	// mostly near the frustum, sometimes far out or at the extremes
	function automatic logic signed [COORD_BITS-1:0] rand_coord();
		int pick;
		pick = $urandom_range(99);
		if (pick < 65)
			return COORD_BITS'(int'($urandom_range(3200)) - 1600);
		if (pick < 85)
			return COORD_BITS'(int'($urandom_range(24000)) - 12000);
		if (pick < 95)
			return COORD_BITS'($urandom);
		case ($urandom_range(3))
			0:       return COORD_BITS'(-32768);
			1:       return COORD_BITS'(32767);
			2:       return '0;
			default: return '1;
		endcase
	endfunction

	function automatic cull_item_t random_item();
		cull_item_t it;
		int pick;
		pick = $urandom_range(99);
		if (pick < 30)
			it.op = OP_POINT;
		else if (pick < 65)
			it.op = OP_BOX;
		else if (pick < 97)
			it.op = OP_SPHERE;
		else
			it.op = OP_UNUSED;
		it.x1 = rand_coord();
		it.y1 = rand_coord();
		it.z1 = rand_coord();
		// half the boxes are small ones around the first corner
		if ($urandom_range(1) == 0) begin
			it.x2 = it.x1 + COORD_BITS'($urandom_range(400));
			it.y2 = it.y1 + COORD_BITS'($urandom_range(400));
			it.z2 = it.z1 + COORD_BITS'($urandom_range(400));
		end else begin
			it.x2 = rand_coord();
			it.y2 = rand_coord();
			it.z2 = rand_coord();
		end
		pick = $urandom_range(99);
		if (pick < 60)
			it.radius = RADIUS_BITS'($urandom_range(800));
		else if (pick < 90)
			it.radius = RADIUS_BITS'($urandom);
		else
			it.radius = $urandom_range(1) ? '1 : '0;
		return it;
	endfunction

	// present one item, hold it until taken, record the prediction
	task automatic send_item(input cull_item_t it);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op       <= it.op;
		x1       <= it.x1;
		y1       <= it.y1;
		z1       <= it.z1;
		x2       <= it.x2;
		y2       <= it.y2;
		z2       <= it.z2;
		radius   <= it.radius;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		board.note_item(it);
	endtask

	// stop sending until every predicted result has been seen
	task automatic drain_results();
		in_valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
	endtask

	// rewrite all six planes while idle, then poke the spare indexes
	task automatic load_planes(input plane_set_t kind);
		fct_plane_t pl;
		drain_results();
		for (int i = 0; i < NUM_PLANES; i++) begin
			pl = build_plane(kind, i);
			wr_en    <= 1'b1;
			wr_index <= CFG_IDX_BITS'(i);
			wr_data  <= pl;
			@(posedge clk);
			board.set_plane(i, pl);
		end
		// spare indexes must not touch any plane
		wr_index <= REG_SPARE_LO;
		wr_data  <= {$urandom, $urandom};
		@(posedge clk);
		wr_index <= REG_SPARE_HI;
		wr_data  <= {$urandom, $urandom};
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic set_idling(input int mode);
		case (mode)
			0: begin
				tx_idle_pct = 22;
				rx_idle_pct = 71;
			end
			1: begin
				tx_idle_pct = 71;
				rx_idle_pct = 22;
			end
			default: begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
		endcase
	endtask

	initial begin
		board = new();
		set_idling(0);
		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// planes still zero after reset: points and boxes culled, spheres visible
		send_item(make_item(OP_POINT, 0, 0, 0, 0, 0, 0, 0));
		send_item(make_item(OP_BOX, -32768, -32768, -32768, 32767, 32767, 32767, 0));
		send_item(make_item(OP_SPHERE, 123, -456, 789, 0, 0, 0, 0));
		send_item(make_item(OP_UNUSED, 5, 5, 5, 6, 6, 6, 9));

		// axis frustum: |x|,|y| below 1000, z between 16 and 2000
		load_planes(SET_AXIS);
		send_item(make_item(OP_POINT, 0, 0, 100, 0, 0, 0, 0));
		// on the right plane is not inside
		send_item(make_item(OP_POINT, 1000, 0, 100, 0, 0, 0, 0));
		send_item(make_item(OP_POINT, 999, 0, 100, 0, 0, 0, 0));
		// on the near plane
		send_item(make_item(OP_POINT, 0, 0, 16, 0, 0, 0, 0));
		send_item(make_item(OP_POINT, 32767, 32767, 32767, 0, 0, 0, 0));
		send_item(make_item(OP_POINT, -32768, -32768, -32768, 0, 0, 0, 0));
		// box spanning the whole coordinate range
		send_item(make_item(OP_BOX, -32768, -32768, -32768, 32767, 32767, 32767, 0));
		// box touching the right plane from outside
		send_item(make_item(OP_BOX, 1000, 0, 100, 1500, 10, 200, 0));
		// corners given in reverse order, one corner just inside
		send_item(make_item(OP_BOX, 1500, 10, 200, 999, 0, 100, 0));
		// box between the near plane and the eye
		send_item(make_item(OP_BOX, -10, -10, 0, 10, 10, 16, 0));
		send_item(make_item(OP_SPHERE, 0, 0, 100, 0, 0, 0, 0));
		// sphere exactly touching the right plane
		send_item(make_item(OP_SPHERE, 1100, 0, 100, 0, 0, 0, 100));
		send_item(make_item(OP_SPHERE, 1101, 0, 100, 0, 0, 0, 100));
		// straddles the right plane but lies beyond the far plane
		send_item(make_item(OP_SPHERE, 1050, 0, 3000, 0, 0, 0, 600));
		send_item(make_item(OP_SPHERE, -32768, -32768, -32768, 0, 0, 0, 32767));
		send_item(make_item(OP_SPHERE, 32767, 32767, 32767, 0, 0, 0, 32767));
		send_item(make_item(OP_UNUSED, 0, 0, 100, 0, 0, 0, 32767));

		// random phases, idling changes every two phases
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			if (ph != 0)
				load_planes(plane_set_t'(ph));
			set_idling(ph / 2);
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				// now and then let the pipeline run dry
				if ($urandom_range(199) == 0)
					drain_results();
				send_item(random_item());
			end
		end

		drain_results();
		if (board.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
